>>> rtl/plti_pkg.sv
// plti_pkg: shared types and codes for the piecewise-linear table interpolator
// used by every module under rtl/ except plti_divu; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

  // operation codes of an input request
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INTERP = 2'd1;
  localparam logic [1:0] OP_EXACT  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         entry_index;
    logic signed [31:0] key_x;
    logic signed [31:0] entry_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [1:0]         status;
  } out_item_t;

  // classified command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_INTERP,
    CMD_EXACT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DATA0,
    BK_MUL0,
    BK_MUL1,
    BK_ADD,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/plti_front.sv
// plti_front: accepts requests, classifies them and queues them (two deep)
// depends on plti_pkg
`timescale 1ns / 1ps
`default_nettype none

module plti_front #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  plti_pkg::in_item_t in_item,
  output logic               cmd_valid,
  output plti_pkg::cmd_t     cmd,
  input  wire                cmd_take
);

  plti_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           pop;
  plti_pkg::cmd_t cls;

  // classify the incoming request
  always_comb begin
    cls.index = in_item.entry_index;
    cls.x     = in_item.key_x;
    cls.y     = in_item.entry_y;
    unique case (in_item.operation)
      plti_pkg::OP_LOAD: begin
        cls.kind = (32'(in_item.entry_index) < TABLE_DEPTH) ?
                   plti_pkg::CMD_LOAD : plti_pkg::CMD_NOP;
      end
      plti_pkg::OP_INTERP: cls.kind = plti_pkg::CMD_INTERP;
      plti_pkg::OP_EXACT:  cls.kind = plti_pkg::CMD_EXACT;
      default:             cls.kind = plti_pkg::CMD_NOP;
    endcase
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> rtl/plti_divu.sv
// plti_divu: 64 by 32 bit unsigned restoring divider, one quotient bit a cycle
// depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module plti_divu (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] num,
  input  wire  [31:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem_r, num_r[63]};
  assign diff   = rem_sh - {1'b0, den_r};

  // one restoring step per cycle
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        num_nxt = {num_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        num_nxt = {num_r[62:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

`default_nettype wire

>>> rtl/plti_back.sv
// plti_back: breakpoint memories, linear key scan, interpolation arithmetic
// and the result register; depends on plti_pkg and plti_divu
`timescale 1ns / 1ps
`default_nettype none

module plti_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [8:0]          cfg_data,
  input  wire                 cmd_valid,
  input  plti_pkg::cmd_t      cmd,
  output logic                cmd_take,
  output logic                out_valid,
  input  wire                 out_stall,
  output plti_pkg::out_item_t out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0] key_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];
  logic [31:0] key_q, val_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [AW+7:0] idx_ext;
  logic          mem_we;

  plti_pkg::back_state_t state_r, state_nxt;
  logic [8:0]    entries_r;
  logic [31:0]   n32;
  logic [AW-1:0] idx_r, idx_nxt;
  plti_pkg::cmd_kind_t kind_r, kind_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic [32:0]   mag_r, mag_nxt;
  logic [31:0]   dxm_r, dxm_nxt, den_r, den_nxt;
  logic          dypos_r, dypos_nxt;
  logic [48:0]   plo_r, plo_nxt, phi_r, phi_nxt;
  plti_pkg::out_item_t res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  plti_pkg::out_item_t out_r, out_nxt;
  logic          out_free;

  logic          ge, eq, last;
  logic signed [32:0] dy;
  logic [32:0]   den33, dxm33;
  logic [63:0]   div_num;
  logic          div_start, div_done;
  logic [63:0]   div_q;

  // saturated entry count
  assign n32 = (32'(entries_r) > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : 32'(entries_r);

  assign cmd_take = cmd_valid && (state_r == plti_pkg::BK_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign idx_ext  = (AW + 8)'(cmd.index);
  assign wr_addr  = idx_ext[AW-1:0];
  assign mem_we   = cmd_take && (cmd.kind == plti_pkg::CMD_LOAD);

  // scan compare on the word read last cycle
  assign ge   = $signed(key_q) >= x_r;
  assign eq   = $signed(key_q) == x_r;
  assign last = (32'(idx_r) + 32'd1) >= n32;

  // difference terms for the interpolation
  assign dy    = 33'(y1_r) - 33'(signed'(val_q));
  assign den33 = 33'(x1_r) - 33'(signed'(key_q));
  assign dxm33 = 33'(x1_r) - 33'(x_r);
  assign div_num = 64'(plo_r) + {phi_r[47:0], 16'd0} + 64'(den_r[31:1]);
  assign div_start = (state_r == plti_pkg::BK_ADD);

  plti_divu u_divu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // breakpoint memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= cmd.x;
      val_mem[wr_addr] <= cmd.y;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plti_pkg::BK_IDLE: begin
        if (cmd_take) begin
          if ((cmd.kind == plti_pkg::CMD_INTERP || cmd.kind == plti_pkg::CMD_EXACT)
              && n32 != 32'd0) begin
            state_nxt = plti_pkg::BK_SCAN;
          end else begin
            state_nxt = plti_pkg::BK_DONE;
          end
        end
      end
      plti_pkg::BK_SCAN: begin
        if (ge) begin
          if (!eq && kind_r == plti_pkg::CMD_INTERP && idx_r != '0) begin
            state_nxt = plti_pkg::BK_DATA0;
          end else begin
            state_nxt = plti_pkg::BK_DONE;
          end
        end else if (last) begin
          state_nxt = plti_pkg::BK_DONE;
        end
      end
      plti_pkg::BK_DATA0: state_nxt = plti_pkg::BK_MUL0;
      plti_pkg::BK_MUL0:  state_nxt = plti_pkg::BK_MUL1;
      plti_pkg::BK_MUL1:  state_nxt = plti_pkg::BK_ADD;
      plti_pkg::BK_ADD:   state_nxt = plti_pkg::BK_DIV;
      plti_pkg::BK_DIV: begin
        if (div_done) begin
          state_nxt = plti_pkg::BK_DONE;
        end
      end
      plti_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = plti_pkg::BK_IDLE;
        end
      end
      default: state_nxt = plti_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    mag_nxt       = mag_r;
    dxm_nxt       = dxm_r;
    den_nxt       = den_r;
    dypos_nxt     = dypos_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    res_nxt       = res_r;
    rd_addr       = '0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      plti_pkg::BK_IDLE: begin
        idx_nxt  = '0;
        kind_nxt = cmd.kind;
        x_nxt    = cmd.x;
        res_nxt.result_y = '0;
        case (cmd.kind)
          plti_pkg::CMD_INTERP: res_nxt.status = plti_pkg::ST_ABOVE;
          plti_pkg::CMD_EXACT:  res_nxt.status = plti_pkg::ST_MISS;
          default:              res_nxt.status = plti_pkg::ST_OK;
        endcase
      end
      plti_pkg::BK_SCAN: begin
        rd_addr = idx_r + AW'(1);
        if (ge) begin
          res_nxt.result_y = '0;
          x1_nxt  = key_q;
          y1_nxt  = val_q;
          rd_addr = idx_r - AW'(1);
          if (eq) begin
            res_nxt.result_y = val_q;
            res_nxt.status   = plti_pkg::ST_OK;
          end else if (kind_r == plti_pkg::CMD_EXACT) begin
            res_nxt.status = plti_pkg::ST_MISS;
          end else if (idx_r == '0) begin
            res_nxt.status = plti_pkg::ST_BELOW;
          end else begin
            res_nxt.status = plti_pkg::ST_OK;
          end
        end else if (!last) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      plti_pkg::BK_DATA0: begin
        mag_nxt   = dy[32] ? 33'(-dy) : 33'(dy);
        dypos_nxt = !dy[32] && (dy != '0);
        den_nxt   = den33[31:0];
        dxm_nxt   = dxm33[31:0];
      end
      plti_pkg::BK_MUL0: plo_nxt = 49'(mag_r) * 49'(dxm_r[15:0]);
      plti_pkg::BK_MUL1: phi_nxt = 49'(mag_r) * 49'(dxm_r[31:16]);
      plti_pkg::BK_ADD: begin
      end
      plti_pkg::BK_DIV: begin
        if (div_done) begin
          res_nxt.result_y = dypos_r ? (y1_r - signed'(div_q[31:0]))
                                     : (y1_r + signed'(div_q[31:0]));
          res_nxt.status   = plti_pkg::ST_OK;
        end
      end
      plti_pkg::BK_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plti_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      entries_r   <= 9'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entries_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    x_r     <= x_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    mag_r   <= mag_nxt;
    dxm_r   <= dxm_nxt;
    den_r   <= den_nxt;
    dypos_r <= dypos_nxt;
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_table_interp.sv
// piecewise_linear_table_interp: top level, front queue plus back engine
// depends on plti_pkg, plti_front, plti_back
//
//   port group | direction | handshake          | payload
//   in_*       | request   | in_valid/in_stall   | plti_pkg::in_item_t
//   out_*      | result    | out_valid/out_stall | plti_pkg::out_item_t
//   cfg_*      | register  | cfg_we              | cfg_data (entries in use)
//
// loads, unused codes and empty-table queries skip the scan; the back engine
//   takes a new request only once the last result is in the output register
// queries: keys are scanned in order (up to the entry count); interpolating
//   ones then pass DATA0, MUL0, MUL1, ADD and the bit-serial 64-step divider
// a two-deep request queue lets new requests enter while a result is stalled
// synchronous active-low reset clears control; table contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  plti_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output plti_pkg::out_item_t out_item,
  input  wire                 cfg_we,
  input  wire  [8:0]          cfg_data
);

  logic           cmd_valid;
  logic           cmd_take;
  plti_pkg::cmd_t cmd;

  // request intake and classification
  plti_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // table search and arithmetic
  plti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/plti_checker.sv
// plti_checker: port-level checks for piecewise_linear_table_interp, with bind
// depends on plti_pkg
`timescale 1ns / 1ps
`default_nettype none

module plti_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input plti_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // failing status carries a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != plti_pkg::ST_OK |-> out_item.result_y == '0)
    else $error("nonzero result with failing status");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
